>>> rtl/ordered_list_insert_delete_engine_macros.svh
// ----------------------------------------------------------------------------
// Ordered list engine assertion macros
// Clocked assertion shorthands shared by the list engine RTL.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_DELETE_ENGINE_MACROS_SVH
`define ORDERED_LIST_INSERT_DELETE_ENGINE_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define OLIDE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold whenever the antecedent holds.
`define OLIDE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/olide_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list engine package
// Field widths, opcodes and status codes shared by the list engine RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package olide_pkg;

  localparam int DATA_W = 32;
  localparam int OPC_W  = 2;
  localparam int STS_W  = 2;

  localparam logic [OPC_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OPC_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OPC_W-1:0] OP_DELETE = 2'd2;
  localparam logic [OPC_W-1:0] OP_DUMP   = 2'd3;

  localparam logic [STS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STS_W-1:0] ST_FULL      = 2'd3;

endpackage

`default_nettype wire

>>> rtl/olide_node_ram.sv
// ----------------------------------------------------------------------------
// Ordered list node store
// Value, next-link and previous-link arrays of the node pool. Each array has
// its own write port; one shared read address returns all three fields of a
// node through a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module olide_node_ram
  import olide_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int LW    = 6
) (
  input  wire logic                     clk,
  input  wire logic                     val_we,
  input  wire logic [AW-1:0]            val_waddr,
  input  wire logic signed [DATA_W-1:0] val_wdata,
  input  wire logic                     nxt_we,
  input  wire logic [AW-1:0]            nxt_waddr,
  input  wire logic [LW-1:0]            nxt_wdata,
  input  wire logic                     prv_we,
  input  wire logic [AW-1:0]            prv_waddr,
  input  wire logic [LW-1:0]            prv_wdata,
  input  wire logic [AW-1:0]            rd_addr,
  output logic signed [DATA_W-1:0]      rd_val,
  output logic [LW-1:0]                 rd_next,
  output logic [LW-1:0]                 rd_prev
);

  logic signed [DATA_W-1:0] val_mem [DEPTH];
  logic [LW-1:0]            nxt_mem [DEPTH];
  logic [LW-1:0]            prv_mem [DEPTH];

  logic signed [DATA_W-1:0] rd_val_r;
  logic [LW-1:0]            rd_next_r;
  logic [LW-1:0]            rd_prev_r;

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_waddr] <= val_wdata;
    end
    if (nxt_we) begin
      nxt_mem[nxt_waddr] <= nxt_wdata;
    end
    if (prv_we) begin
      prv_mem[prv_waddr] <= prv_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_val_r  <= val_mem[rd_addr];
    rd_next_r <= nxt_mem[rd_addr];
    rd_prev_r <= prv_mem[rd_addr];
  end

  assign rd_val  = rd_val_r;
  assign rd_next = rd_next_r;
  assign rd_prev = rd_prev_r;

endmodule

`default_nettype wire

>>> rtl/ordered_list_insert_delete_engine.sv
// ----------------------------------------------------------------------------
// Ordered list insert/delete engine
// Doubly linked list of signed values over a fixed node pool.
// ----------------------------------------------------------------------------
// Usage: one transaction on the in_ channel carries an opcode (append, insert
// left of key, delete key, dump) with a new value and a search key. in_stall
// is high while an item is being worked on; one item is handled at a time.
// Every item except a dump of a non-empty list returns one out_ transaction
// with out_last_result set. A dump returns one transaction per stored value,
// head to tail, the final one marked by out_last_result.
// Steps: append does a free-node scan and then relinks, delete walks to the
// key and unlinks, and insert walks and then scans. The node walk reads one
// node per cycle through the single read port of the node store; the free
// scan tests one pool bit per cycle. While the receiver does not stall, a
// dump streams one value per cycle. Each single result passes through the
// output register.
// If the receiver stalls, the result waits in the output register, and the
// engine holds in its response or dump step until the register is free.
// After reset the list is empty and every node is free; no clearing pass is
// needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ordered_list_insert_delete_engine_macros.svh"

module ordered_list_insert_delete_engine
  import olide_pkg::*;
#(
  parameter int POOL_NODES = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [OPC_W-1:0]         in_opcode,
  input  wire logic signed [DATA_W-1:0] in_new_value,
  input  wire logic signed [DATA_W-1:0] in_search_key,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [STS_W-1:0]              out_status,
  output logic signed [DATA_W-1:0]      out_dump_value,
  output logic                          out_last_result
);

  localparam int AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int LW = $clog2(POOL_NODES + 1);
  localparam logic [LW-1:0] NONE     = LW'(POOL_NODES);
  localparam logic [AW-1:0] LAST_IDX = AW'(POOL_NODES - 1);

  localparam int SW = 3;
  localparam logic [SW-1:0] S_IDLE  = 3'd0;
  localparam logic [SW-1:0] S_WALK  = 3'd1;
  localparam logic [SW-1:0] S_SCAN  = 3'd2;
  localparam logic [SW-1:0] S_LINK1 = 3'd3;
  localparam logic [SW-1:0] S_LINK2 = 3'd4;
  localparam logic [SW-1:0] S_DEL   = 3'd5;
  localparam logic [SW-1:0] S_DUMP  = 3'd6;
  localparam logic [SW-1:0] S_RESP  = 3'd7;

  // Control state
  logic [SW-1:0]         state_r, state_nxt;
  logic [LW-1:0]         head_r, head_nxt;
  logic [LW-1:0]         tail_r, tail_nxt;
  logic [POOL_NODES-1:0] free_r, free_nxt;
  logic [LW-1:0]         count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Item and walk payload
  logic [OPC_W-1:0]         op_r, op_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic signed [DATA_W-1:0] key_r, key_nxt;
  logic [AW-1:0]            cur_r, cur_nxt;
  logic [AW-1:0]            step_r, step_nxt;
  logic [AW-1:0]            tgt_r, tgt_nxt;
  logic [LW-1:0]            tprev_r, tprev_nxt;
  logic [LW-1:0]            tnext_r, tnext_nxt;
  logic [AW-1:0]            new_r, new_nxt;
  logic [STS_W-1:0]         sts_r, sts_nxt;
  logic [STS_W-1:0]         out_status_r, out_status_nxt;
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  logic                     out_last_r, out_last_nxt;

  // Node store ports
  logic                     val_we;
  logic [AW-1:0]            val_waddr;
  logic signed [DATA_W-1:0] val_wdata;
  logic                     nxt_we;
  logic [AW-1:0]            nxt_waddr;
  logic [LW-1:0]            nxt_wdata;
  logic                     prv_we;
  logic [AW-1:0]            prv_waddr;
  logic [LW-1:0]            prv_wdata;
  logic [AW-1:0]            rd_addr;
  logic signed [DATA_W-1:0] rd_val;
  logic [LW-1:0]            rd_next;
  logic [LW-1:0]            rd_prev;

  logic out_free;
  logic dump_last;

  olide_node_ram #(
    .DEPTH (POOL_NODES),
    .AW    (AW),
    .LW    (LW)
  ) u_node_ram (
    .clk       (clk),
    .val_we    (val_we),
    .val_waddr (val_waddr),
    .val_wdata (val_wdata),
    .nxt_we    (nxt_we),
    .nxt_waddr (nxt_waddr),
    .nxt_wdata (nxt_wdata),
    .prv_we    (prv_we),
    .prv_waddr (prv_waddr),
    .prv_wdata (prv_wdata),
    .rd_addr   (rd_addr),
    .rd_val    (rd_val),
    .rd_next   (rd_next),
    .rd_prev   (rd_prev)
  );

  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign dump_last = (rd_next == NONE) || (step_r == LAST_IDX);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    free_nxt       = free_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    key_nxt        = key_r;
    cur_nxt        = cur_r;
    step_nxt       = step_r;
    tgt_nxt        = tgt_r;
    tprev_nxt      = tprev_r;
    tnext_nxt      = tnext_r;
    new_nxt        = new_r;
    sts_nxt        = sts_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;

    // The read address normally stays on the current node, so the node
    // store output holds while a result waits for the receiver.
    rd_addr   = cur_r;
    val_we    = 1'b0;
    val_waddr = new_r;
    val_wdata = val_r;
    nxt_we    = 1'b0;
    nxt_waddr = new_r;
    nxt_wdata = NONE;
    prv_we    = 1'b0;
    prv_waddr = new_r;
    prv_wdata = NONE;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_opcode;
          val_nxt  = in_new_value;
          key_nxt  = in_search_key;
          step_nxt = '0;
          cur_nxt  = head_r[AW-1:0];
          rd_addr  = head_r[AW-1:0];
          if (in_opcode == OP_APPEND) begin
            state_nxt = S_SCAN;
          end else if (head_r == NONE) begin
            sts_nxt   = ST_EMPTY;
            state_nxt = S_RESP;
          end else if (in_opcode == OP_DUMP) begin
            state_nxt = S_DUMP;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (rd_val == key_r) begin
          tgt_nxt   = cur_r;
          tprev_nxt = rd_prev;
          tnext_nxt = rd_next;
          step_nxt  = '0;
          state_nxt = (op_r == OP_INSERT) ? S_SCAN : S_DEL;
        end else if ((rd_next == NONE) || (step_r == LAST_IDX)) begin
          sts_nxt   = ST_NOT_FOUND;
          state_nxt = S_RESP;
        end else begin
          rd_addr  = rd_next[AW-1:0];
          cur_nxt  = rd_next[AW-1:0];
          step_nxt = step_r + 1'b1;
        end
      end
      S_SCAN: begin
        // Lowest-numbered free node, one pool bit per cycle.
        if (free_r[step_r]) begin
          new_nxt   = step_r;
          state_nxt = S_LINK1;
        end else if (step_r == LAST_IDX) begin
          sts_nxt   = ST_FULL;
          state_nxt = S_RESP;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_LINK1: begin
        val_we = 1'b1;
        nxt_we = 1'b1;
        prv_we = 1'b1;
        if (op_r == OP_APPEND) begin
          nxt_wdata = NONE;
          prv_wdata = tail_r;
        end else begin
          nxt_wdata = LW'(tgt_r);
          prv_wdata = tprev_r;
        end
        state_nxt = S_LINK2;
      end
      S_LINK2: begin
        nxt_wdata = LW'(new_r);
        prv_wdata = LW'(new_r);
        if (op_r == OP_APPEND) begin
          if (tail_r != NONE) begin
            nxt_we    = 1'b1;
            nxt_waddr = tail_r[AW-1:0];
          end else begin
            head_nxt = LW'(new_r);
          end
          tail_nxt = LW'(new_r);
        end else begin
          if (tprev_r != NONE) begin
            nxt_we    = 1'b1;
            nxt_waddr = tprev_r[AW-1:0];
          end else begin
            head_nxt = LW'(new_r);
          end
          prv_we    = 1'b1;
          prv_waddr = tgt_r;
        end
        free_nxt[new_r] = 1'b0;
        count_nxt       = count_r + 1'b1;
        sts_nxt         = ST_OK;
        state_nxt       = S_RESP;
      end
      S_DEL: begin
        nxt_wdata = tnext_r;
        prv_wdata = tprev_r;
        if (tprev_r != NONE) begin
          nxt_we    = 1'b1;
          nxt_waddr = tprev_r[AW-1:0];
        end else begin
          head_nxt = tnext_r;
        end
        if (tnext_r != NONE) begin
          prv_we    = 1'b1;
          prv_waddr = tnext_r[AW-1:0];
        end else begin
          tail_nxt = tprev_r;
        end
        free_nxt[tgt_r] = 1'b1;
        if (count_r != '0) begin
          count_nxt = count_r - 1'b1;
        end
        sts_nxt   = ST_OK;
        state_nxt = S_RESP;
      end
      S_DUMP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_value_nxt  = rd_val;
          out_last_nxt   = dump_last;
          if (dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            rd_addr  = rd_next[AW-1:0];
            cur_nxt  = rd_next[AW-1:0];
            step_nxt = step_r + 1'b1;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = sts_r;
          out_value_nxt  = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= NONE;
      tail_r      <= NONE;
      free_r      <= '1;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_r      <= free_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    key_r        <= key_nxt;
    cur_r        <= cur_nxt;
    step_r       <= step_nxt;
    tgt_r        <= tgt_nxt;
    tprev_r      <= tprev_nxt;
    tnext_r      <= tnext_nxt;
    new_r        <= new_nxt;
    sts_r        <= sts_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_dump_value  = out_value_r;
  assign out_last_result = out_last_r;

  // Every node is either free or linked in the list.
  `OLIDE_ASSERT_ALWAYS(a_pool_balance,
    ($countones(free_r) + int'(count_r)) == POOL_NODES, "pool and list counts disagree")
  `OLIDE_ASSERT_ALWAYS(a_empty_match,
    (count_r == '0) == (head_r == NONE), "entry count and head disagree")
  `OLIDE_ASSERT_ALWAYS(a_ends_match,
    (head_r == NONE) == (tail_r == NONE), "head and tail disagree on empty list")
  // Only a dump produces results that are not the final one of an item.
  `OLIDE_ASSERT_IMPLIES(a_partial_in_dump,
    out_valid_r && !out_last_r, state_r == S_DUMP, "non-final result outside dump")

endmodule

`default_nettype wire
